// ===== rtl/lca_pkg.sv =====
// ----------------------------------------------------------------------------
// lca_pkg: shared types, constants and the row update function
// Grid geometry, operation codes, register map, configuration struct and the
// per-row next-generation logic of the life-like cellular automaton.
// ----------------------------------------------------------------------------
package lca_pkg;

  // Grid geometry: the memory holds one row per entry.
  localparam int ROWS  = 64;
  localparam int COLS  = 64;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  // Fixed widths of the command and configuration fields.
  localparam int OP_W    = 2;
  localparam int IDX_W   = 6;
  localparam int MASK_W  = 9;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int REGI_W  = ADDR_W - 2;

  typedef logic [COLS-1:0] row_t;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2,
    OP_CLEAR = 2'd3
  } lca_op_e;

  // Register indexes on the configuration port.
  localparam logic [REGI_W-1:0] REG_BIRTH   = 2'd0;
  localparam logic [REGI_W-1:0] REG_SURVIVE = 2'd1;
  localparam logic [REGI_W-1:0] REG_WRAP    = 2'd2;

  // Reset values of the rule registers.
  localparam logic [MASK_W-1:0] BIRTH_RST   = 9'd8;
  localparam logic [MASK_W-1:0] SURVIVE_RST = 9'd12;
  localparam logic              WRAP_RST    = 1'b1;

  typedef struct packed {
    logic [MASK_W-1:0] birth;
    logic [MASK_W-1:0] survive;
    logic              wrap;
  } lca_cfg_t;

  // Computes the next generation of one row from the rows above and below.
  // Each column is an independent lane: count eight neighbors, then pick
  // the rule bit from the survive or birth mask.
  function automatic row_t next_row(
    row_t              above,
    row_t              cur,
    row_t              below,
    logic              wrap,
    logic [MASK_W-1:0] birth,
    logic [MASK_W-1:0] survive
  );
    row_t       res;
    logic [3:0] cnt;
    logic       al;
    logic       ml;
    logic       bl;
    logic       ar;
    logic       mr;
    logic       br;
    for (int c = 0; c < COLS; c++) begin
      if (c == 0) begin
        al = wrap & above[COLS-1];
        ml = wrap & cur[COLS-1];
        bl = wrap & below[COLS-1];
      end else begin
        al = above[c-1];
        ml = cur[c-1];
        bl = below[c-1];
      end
      if (c == COLS - 1) begin
        ar = wrap & above[0];
        mr = wrap & cur[0];
        br = wrap & below[0];
      end else begin
        ar = above[c+1];
        mr = cur[c+1];
        br = below[c+1];
      end
      cnt = {3'b000, al} + {3'b000, above[c]} + {3'b000, ar}
          + {3'b000, ml} + {3'b000, mr}
          + {3'b000, bl} + {3'b000, below[c]} + {3'b000, br};
      res[c] = cur[c] ? survive[cnt] : birth[cnt];
    end
    return res;
  endfunction

endpackage

// ===== rtl/life_like_cellular_automaton.sv =====
// ----------------------------------------------------------------------------
// life_like_cellular_automaton: row-memory cellular automaton engine
// Read cell and write cell fetch the addressed row, then raise done_o; clear
// zeroes the rows in turn; a generation step primes the row buffers, then
// updates one memory row per cycle through the single read and write ports.
// One transaction at a time: busy is high until the done_o pulse.
// After reset a clearing sweep over all rows runs with busy high and no result.
// The done_o pulse lasts one cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module life_like_cellular_automaton (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [lca_pkg::OP_W-1:0]    operation_i,
  input  logic [lca_pkg::IDX_W-1:0]   row_i,
  input  logic [lca_pkg::IDX_W-1:0]   col_i,
  input  logic                        cell_value_i,
  // Result channel
  output logic                        done_o,
  output logic                        read_value_o,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lca_pkg::ADDR_W-1:0]  paddr,
  input  logic [lca_pkg::DATA_W-1:0]  pwdata,
  output logic [lca_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_WRITE,
    ST_FIRST,
    ST_LOAD,
    ST_CALC
  } state_e;

  state_e                    state_q, state_d;
  logic [lca_pkg::ROW_W-1:0] r_q, r_d;
  logic                      clr_op_q, clr_op_d;
  logic                      done_q, done_d;
  logic                      rdval_q, rdval_d;

  // Latched command payload.
  logic [lca_pkg::ROW_W-1:0] row_q;
  logic [lca_pkg::COL_W-1:0] col_q;
  logic                      val_q;
  logic                      in_grid_q;

  // Row buffers for the generation sweep.
  lca_pkg::row_t             above_q;
  lca_pkg::row_t             cur_q;
  lca_pkg::row_t             first_q;

  lca_pkg::lca_cfg_t         cfg;
  lca_pkg::lca_op_e          op;
  logic [lca_pkg::ROW_W-1:0] row_idx;
  logic [lca_pkg::COL_W-1:0] col_idx;
  logic                      in_grid;
  logic                      accept;
  logic                      latch_cmd;

  logic                      mem_we;
  logic [lca_pkg::ROW_W-1:0] mem_waddr;
  lca_pkg::row_t             mem_wdata;
  logic [lca_pkg::ROW_W-1:0] mem_raddr;
  lca_pkg::row_t             mem_rdata;

  lca_pkg::row_t             above_eff;
  lca_pkg::row_t             below_eff;
  lca_pkg::row_t             new_row;
  lca_pkg::row_t             wr_row;

  // Configuration registers.
  lca_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Grid storage, one row per entry.
  lca_ram #(
    .DEPTH (lca_pkg::ROWS),
    .WIDTH (lca_pkg::COLS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Command decode.
  assign op      = lca_pkg::lca_op_e'(operation_i);
  assign row_idx = lca_pkg::ROW_W'(row_i);
  assign col_idx = lca_pkg::COL_W'(col_i);
  assign in_grid = (32'(row_i) < lca_pkg::ROWS) && (32'(col_i) < lca_pkg::COLS);
  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;

  // Edge handling for the rows above and below the current one. The original
  // top row is kept in first_q since it is overwritten before the last row.
  assign above_eff = ((r_q == '0) && !cfg.wrap) ? '0 : above_q;
  assign below_eff = (r_q == lca_pkg::ROW_LAST) ? (cfg.wrap ? first_q : '0) : mem_rdata;
  assign new_row   = lca_pkg::next_row(above_eff, cur_q, below_eff, cfg.wrap,
                                       cfg.birth, cfg.survive);

  // Read-modify-write row for a single cell write.
  always_comb begin
    wr_row         = mem_rdata;
    wr_row[col_q]  = val_q;
  end

  // Sequencer: next state, memory port control and result.
  always_comb begin
    state_d   = state_q;
    r_d       = r_q;
    clr_op_d  = clr_op_q;
    done_d    = 1'b0;
    rdval_d   = 1'b0;
    latch_cmd = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = r_q;
    mem_wdata = '0;
    mem_raddr = row_idx;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          latch_cmd = 1'b1;
          unique case (op)
            lca_pkg::OP_WRITE: state_d = ST_WRITE;
            lca_pkg::OP_READ:  state_d = ST_READ;
            lca_pkg::OP_STEP: begin
              mem_raddr = lca_pkg::ROW_LAST;
              state_d   = ST_FIRST;
            end
            lca_pkg::OP_CLEAR: begin
              r_d      = '0;
              clr_op_d = 1'b1;
              state_d  = ST_CLEAR;
            end
          endcase
        end
      end
      ST_READ: begin
        rdval_d = in_grid_q & mem_rdata[col_q];
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_WRITE: begin
        mem_we    = in_grid_q;
        mem_waddr = row_q;
        mem_wdata = wr_row;
        done_d    = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_FIRST: begin
        // Last row arrives now; fetch the top row.
        mem_raddr = '0;
        state_d   = ST_LOAD;
      end
      ST_LOAD: begin
        // Top row arrives now; fetch the second row.
        mem_raddr = lca_pkg::ROW_W'(1);
        r_d       = '0;
        state_d   = ST_CALC;
      end
      ST_CALC: begin
        // Row r+1 arrives now; write row r and prefetch row r+2.
        mem_raddr = (r_q >= lca_pkg::ROW_LAST - lca_pkg::ROW_W'(1)) ?
                    '0 : r_q + lca_pkg::ROW_W'(2);
        mem_we    = 1'b1;
        mem_waddr = r_q;
        mem_wdata = new_row;
        if (r_q == lca_pkg::ROW_LAST) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          r_d = r_q + lca_pkg::ROW_W'(1);
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = r_q;
        mem_wdata = '0;
        if (r_q == lca_pkg::ROW_LAST) begin
          done_d  = clr_op_q;
          state_d = ST_IDLE;
        end else begin
          r_d = r_q + lca_pkg::ROW_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and registered outputs; reset starts the clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      r_q      <= '0;
      clr_op_q <= 1'b0;
      done_q   <= 1'b0;
      rdval_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      r_q      <= r_d;
      clr_op_q <= clr_op_d;
      done_q   <= done_d;
      rdval_q  <= rdval_d;
    end
  end

  // Payload registers: command fields and row buffers.
  always_ff @(posedge clk_i) begin
    if (latch_cmd) begin
      row_q     <= row_idx;
      col_q     <= col_idx;
      val_q     <= cell_value_i;
      in_grid_q <= in_grid;
    end
    if (state_q == ST_FIRST) begin
      above_q <= mem_rdata;
    end
    if (state_q == ST_LOAD) begin
      cur_q   <= mem_rdata;
      first_q <= mem_rdata;
    end
    if (state_q == ST_CALC) begin
      above_q <= cur_q;
      cur_q   <= below_eff;
    end
  end

  assign done_o       = done_q;
  assign read_value_o = rdval_q;

endmodule

// ===== rtl/lca_ram.sv =====
// ----------------------------------------------------------------------------
// lca_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address. No reset on the storage.
// ----------------------------------------------------------------------------
module lca_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/lca_cfg.sv =====
// ----------------------------------------------------------------------------
// lca_cfg: APB-style configuration registers
// Holds the birth mask, survive mask and edge wrap control. Writes complete
// in the access phase; pready is always high and reads are combinational.
// ----------------------------------------------------------------------------
module lca_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lca_pkg::ADDR_W-1:0]  paddr,
  input  logic [lca_pkg::DATA_W-1:0]  pwdata,
  output logic [lca_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output lca_pkg::lca_cfg_t           cfg_o
);

  logic [lca_pkg::MASK_W-1:0] birth_q;
  logic [lca_pkg::MASK_W-1:0] survive_q;
  logic                       wrap_q;
  logic [lca_pkg::REGI_W-1:0] reg_idx;
  logic                       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lca_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; an index beyond the map is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_q   <= lca_pkg::BIRTH_RST;
      survive_q <= lca_pkg::SURVIVE_RST;
      wrap_q    <= lca_pkg::WRAP_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        lca_pkg::REG_BIRTH:   birth_q   <= pwdata[lca_pkg::MASK_W-1:0];
        lca_pkg::REG_SURVIVE: survive_q <= pwdata[lca_pkg::MASK_W-1:0];
        lca_pkg::REG_WRAP:    wrap_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      lca_pkg::REG_BIRTH:   prdata = lca_pkg::DATA_W'(birth_q);
      lca_pkg::REG_SURVIVE: prdata = lca_pkg::DATA_W'(survive_q);
      lca_pkg::REG_WRAP:    prdata = lca_pkg::DATA_W'(wrap_q);
      default:              prdata = '0;
    endcase
  end

  assign cfg_o.birth   = birth_q;
  assign cfg_o.survive = survive_q;
  assign cfg_o.wrap    = wrap_q;

endmodule

// ===== rtl/lca_checker.sv =====
// ----------------------------------------------------------------------------
// lca_checker: port-level checks for the cellular automaton
// Watches the command and result ports and flags sequencing errors.
// ----------------------------------------------------------------------------
module lca_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic read_value_o
);

  // An accepted transaction makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted transaction");

  // No transaction completes in the cycle right after it is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o)
    else $error("result appeared one cycle after acceptance");

  // The completion strobe is a single-cycle pulse.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("completion strobe longer than one cycle");

  // A result is shown only when the block is ready for the next transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while still busy");

  // The read value is zero outside a result cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !read_value_o)
    else $error("read value set without a result");

endmodule

bind life_like_cellular_automaton lca_checker u_lca_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .read_value_o (read_value_o)
);
